/* rtl/rhf_pkg.sv */
// ----------------------------------------------------------------------------
// rhf_pkg: shared types and constants of the region hint filter.
// Holds table geometry, advice and outcome codes, and the slot record type.
// ----------------------------------------------------------------------------
`default_nettype none

package rhf_pkg;

   localparam int unsigned TableEntries = 8192;
   localparam int unsigned ProbeLimit   = 8;
   localparam int unsigned IdxW         = $clog2(TableEntries);
   localparam int unsigned ProbeW       = $clog2(ProbeLimit + 1);

   localparam logic [63:0] HashMul  = 64'd2654435761;
   localparam logic [29:0] NsPerSec = 30'd1000000000;

   localparam logic [1:0] ADV_NONE   = 2'd0;
   localparam logic [1:0] ADV_HUGE   = 2'd1;
   localparam logic [1:0] ADV_NOHUGE = 2'd2;

   localparam logic [2:0] OUT_ISSUE    = 3'd0;
   localparam logic [2:0] OUT_READONLY = 3'd1;
   localparam logic [2:0] OUT_TYPE     = 3'd2;
   localparam logic [2:0] OUT_SIZE     = 3'd3;
   localparam logic [2:0] OUT_RECENT   = 3'd4;

   localparam logic [2:0] TYPE_ANON  = 3'd0;
   localparam logic [2:0] TYPE_HEAP  = 3'd1;
   localparam logic [2:0] TYPE_STACK = 3'd2;

   localparam logic [2:0] CSR_HUGE_TH  = 3'd0;
   localparam logic [2:0] CSR_WIN_LO   = 3'd1;
   localparam logic [2:0] CSR_WIN_HI   = 3'd2;
   localparam logic [2:0] CSR_WIN_EN   = 3'd3;
   localparam logic [2:0] CSR_TTL      = 3'd4;
   localparam logic [2:0] CSR_ANON     = 3'd5;
   localparam logic [2:0] CSR_HEAP     = 3'd6;
   localparam logic [2:0] CSR_STACK    = 3'd7;

   typedef struct packed {
      logic [22:0] pid;
      logic [47:0] start;
      logic [47:0] stop;
      logic [63:0] stamp;
      logic [1:0]  advice;
   } slot_type;

endpackage

`default_nettype wire

/* rtl/rhf_slot_ram.sv */
// ----------------------------------------------------------------------------
// rhf_slot_ram: one-read one-write slot table with registered read data.
// A clearing pass stamps each entry empty after reset; ready marks its end.
// ----------------------------------------------------------------------------
`default_nettype none

module rhf_slot_ram (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    rd_en,
   input  wire logic [rhf_pkg::IdxW-1:0] rd_addr,
   output rhf_pkg::slot_type            rd_data,
   input  wire logic                    wr_en,
   input  wire logic [rhf_pkg::IdxW-1:0] wr_addr,
   input  rhf_pkg::slot_type            wr_data,
   output logic                         ready
);
   import rhf_pkg::*;

   slot_type mem [TableEntries];
   slot_type rd_ff;
   logic [IdxW:0] clr_ff, clr_in;
   logic          clearing;

   assign clearing = !clr_ff[IdxW];
   assign ready    = !clearing;
   assign rd_data  = rd_ff;

   always_comb begin
      clr_in = clr_ff;
      if (clearing) clr_in = clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else clr_ff <= clr_in;
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         mem[clr_ff[IdxW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) rd_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/region_hint_filter_ttl_cache.sv */
// ----------------------------------------------------------------------------
// region_hint_filter_ttl_cache: region advice filter with a TTL cache.
//
// Each item on the req_ channel describes one memory region. The block
// filters it by write permission and type, picks huge or avoid-huge
// advice by size, and looks the decision up in a linearly probed hash
// table so that a repeat within the TTL is suppressed. Exactly one result
// item leaves on the rsp_ channel for every request item.
// An item that reaches the table has its hash and TTL products formed,
// then takes one read of the slot memory per probe, up to eight probes,
// and one write-back. One item is worked on at a time; a new one is
// taken while the previous result still waits in the output register.
// After reset a clearing pass over all 8192 entries empties the table;
// no item is accepted meanwhile, while csr_ writes are taken at once.
// When the receiver stalls, the result holds and the block stops after
// its work.
// ----------------------------------------------------------------------------
`default_nettype none

module region_hint_filter_ttl_cache (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [22:0] req_process_id,
   input  wire logic [47:0] req_region_start,
   input  wire logic [47:0] req_region_end,
   input  wire logic        req_writable,
   input  wire logic [2:0]  req_region_type,
   input  wire logic [63:0] req_timestamp,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_advice,
   output logic [2:0]       rsp_outcome,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import rhf_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLASS = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // Configuration registers.
   logic [31:0] huge_th_ff, win_lo_ff, win_hi_ff;
   logic        win_en_ff, anon_ff, heap_ff, stack_ff;
   logic [15:0] ttl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         huge_th_ff <= 32'd128;
         win_lo_ff  <= 32'd16;
         win_hi_ff  <= 32'd64;
         win_en_ff  <= 1'b1;
         ttl_ff     <= 16'd30;
         anon_ff    <= 1'b1;
         heap_ff    <= 1'b1;
         stack_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HUGE_TH: huge_th_ff <= csr_data;
            CSR_WIN_LO:  win_lo_ff  <= csr_data;
            CSR_WIN_HI:  win_hi_ff  <= csr_data;
            CSR_WIN_EN:  win_en_ff  <= csr_data[0];
            CSR_TTL:     ttl_ff     <= csr_data[15:0];
            CSR_ANON:    anon_ff    <= csr_data[0];
            CSR_HEAP:    heap_ff    <= csr_data[0];
            CSR_STACK:   stack_ff   <= csr_data[0];
            default:     ;
         endcase
      end
   end

   // Item registers.
   logic [2:0]  state_ff, state_in;
   logic [22:0] pid_ff;
   logic [47:0] start_ff, end_ff;
   logic        wr_ff;
   logic [2:0]  type_ff;
   logic [63:0] now_ff;
   logic [1:0]  adv_ff, adv_in;
   logic [63:0] pmul_ff, ttl_ns_ff;
   logic [IdxW-1:0] vict_ff, idx_ff;
   logic [63:0] vage_ff;
   logic [ProbeW-1:0] probe_ff;
   logic        hit_ff;
   logic        rsp_v_ff, rsp_v_in;
   logic [1:0]  rsp_adv_ff, res_adv_ff;
   logic [2:0]  rsp_out_ff, res_out_ff;
   logic        ram_ready;
   slot_type    rd_data, wr_data;
   logic        rd_en, wr_en;
   logic [IdxW-1:0] wr_addr;

   assign req_ready   = (state_ff == ST_IDLE) && ram_ready;
   assign rsp_valid   = rsp_v_ff;
   assign rsp_advice  = rsp_adv_ff;
   assign rsp_outcome = rsp_out_ff;

   // Classification of the latched item.
   logic [37:0] size_kb;
   logic        allowed, is_huge, is_small;
   logic [47:0] diff;
   assign diff    = end_ff - start_ff;
   assign size_kb = diff[47:10];
   always_comb begin
      unique case (type_ff)
         TYPE_ANON:  allowed = anon_ff;
         TYPE_HEAP:  allowed = heap_ff;
         TYPE_STACK: allowed = stack_ff;
         default:    allowed = 1'b0;
      endcase
   end
   assign is_huge  = size_kb >= {6'd0, huge_th_ff};
   assign is_small = win_en_ff && (type_ff == TYPE_ANON) &&
                     (size_kb >= {6'd0, win_lo_ff}) && (size_kb < {6'd0, win_hi_ff});

   // Probe evaluation on the registered slot read.
   logic [63:0] hash, age;
   logic        match, reuse;
   assign hash  = pmul_ff ^ {16'd0, start_ff} ^ {3'd0, end_ff, 13'd0} ^
                  {15'd0, adv_ff, 47'd0};
   assign age   = now_ff - rd_data.stamp;
   assign match = (rd_data.pid != '0) && (rd_data.pid == pid_ff) &&
                  (rd_data.start == start_ff) && (rd_data.stop == end_ff) &&
                  (rd_data.advice == adv_ff);
   assign reuse = (rd_data.pid == '0) || (age >= ttl_ns_ff);

   assign rd_en   = (state_ff == ST_READ);
   assign wr_data = '{pid: pid_ff, start: start_ff, stop: end_ff,
                      stamp: now_ff, advice: adv_ff};
   assign wr_en   = (state_ff == ST_WRITE);
   assign wr_addr = idx_ff;

   rhf_slot_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ready   (ram_ready)
   );

   assign adv_in = is_huge ? ADV_HUGE : ADV_NOHUGE;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid && req_ready) state_in = ST_CLASS;
         ST_CLASS: begin
            if (!wr_ff || !allowed || !(is_huge || is_small)) state_in = ST_DONE;
            else state_in = ST_HASH;
         end
         ST_HASH:  state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (match || reuse || (probe_ff == ProbeW'(ProbeLimit - 1)))
               state_in = ST_WRITE;
            else state_in = ST_READ;
         end
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (!rsp_v_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // The output register is loaded from DONE once it is free or being emptied.
   always_comb begin
      rsp_v_in = rsp_v_ff;
      if (rsp_v_ff && rsp_ready) rsp_v_in = 1'b0;
      if (state_ff == ST_DONE && (!rsp_v_ff || rsp_ready)) rsp_v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   // Payload path. The result is built in res_ registers so that a result
   // still waiting at the output keeps its value.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            pid_ff   <= req_process_id;
            start_ff <= req_region_start;
            end_ff   <= req_region_end;
            wr_ff    <= req_writable;
            type_ff  <= req_region_type;
            now_ff   <= req_timestamp;
            hit_ff   <= 1'b0;
         end
         ST_CLASS: begin
            adv_ff    <= adv_in;
            pmul_ff   <= {41'd0, pid_ff} * HashMul;
            ttl_ns_ff <= {48'd0, ttl_ff} * {34'd0, NsPerSec};
            if (!wr_ff) begin
               res_adv_ff <= ADV_NONE; res_out_ff <= OUT_READONLY;
            end else if (!allowed) begin
               res_adv_ff <= ADV_NONE; res_out_ff <= OUT_TYPE;
            end else if (!(is_huge || is_small)) begin
               res_adv_ff <= ADV_NONE; res_out_ff <= OUT_SIZE;
            end
         end
         ST_HASH: begin
            idx_ff   <= hash[IdxW-1:0];
            vict_ff  <= hash[IdxW-1:0];
            vage_ff  <= '0;
            probe_ff <= '0;
         end
         ST_READ: ;
         ST_CHECK: begin
            if (match) begin
               hit_ff <= (age < ttl_ns_ff);
            end else if (reuse) begin
               hit_ff <= 1'b0;
            end else if (probe_ff == ProbeW'(ProbeLimit - 1)) begin
               idx_ff <= (age > vage_ff) ? idx_ff : vict_ff;
            end else begin
               if (age > vage_ff) begin
                  vage_ff <= age;
                  vict_ff <= idx_ff;
               end
               idx_ff   <= idx_ff + 1'b1;
               probe_ff <= probe_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            res_adv_ff <= hit_ff ? ADV_NONE : adv_ff;
            res_out_ff <= hit_ff ? OUT_RECENT : OUT_ISSUE;
         end
         ST_DONE: begin
            if (!rsp_v_ff || rsp_ready) begin
               rsp_adv_ff <= res_adv_ff;
               rsp_out_ff <= res_out_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire
